FILE: rtl/core/hpr_pkg.sv
package hpr_pkg;

  localparam int ANGLE_BITS_DEF     = 32;
  localparam int NSIDE_MAX_LOG2_DEF = 13;
  localparam int NSIDE_W            = 14;
  localparam int PIX_W              = 30;
  localparam int CORDIC_STEPS       = 32;
  localparam int SQRT_STEPS         = 32;

  // CORDIC start value, aggregate gain folded in (Q.32)
  localparam logic signed [35:0] CORDIC_GAIN = 36'sh09B74EDA8;

  typedef logic signed [35:0] cval_t;
  typedef logic signed [34:0] cang_t;

  // travels alongside the CORDIC
  typedef struct packed {
    logic        neg;
    logic [31:0] t;
  } cside_t;

  // travels alongside the square root and the index stages
  typedef struct packed {
    logic        neg;
    logic        belt;
    logic [30:0] za;
    logic [31:0] t;
  } sside_t;

  // arctan(2^-i) in units of pi/2^32
  function automatic logic [31:0] atan_val(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h40000000;
      1:  v = 32'h25C80A3C;
      2:  v = 32'h13F670B6;
      3:  v = 32'h0A2223A8;
      4:  v = 32'h05161A86;
      5:  v = 32'h028BAFC2;
      6:  v = 32'h0145EC3C;
      7:  v = 32'h00A2F8AA;
      8:  v = 32'h00517CA6;
      9:  v = 32'h0028BE5E;
      10: v = 32'h00145F30;
      11: v = 32'h000A2F98;
      12: v = 32'h000517CC;
      13: v = 32'h00028BE6;
      14: v = 32'h000145F4;
      15: v = 32'h0000A2FA;
      16: v = 32'h0000517C;
      17: v = 32'h000028BE;
      18: v = 32'h00001460;
      19: v = 32'h00000A30;
      20: v = 32'h00000518;
      21: v = 32'h0000028C;
      22: v = 32'h00000146;
      23: v = 32'h000000A2;
      24: v = 32'h00000052;
      25: v = 32'h00000028;
      26: v = 32'h00000014;
      27: v = 32'h0000000A;
      28: v = 32'h00000006;
      29: v = 32'h00000002;
      30: v = 32'h00000002;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/hpr_cordic.sv
module hpr_cordic (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [32:0]     in_r,
  input  hpr_pkg::cside_t in_side,
  output logic            out_valid,
  output hpr_pkg::cval_t  out_x,
  output hpr_pkg::cside_t out_side
);
  import hpr_pkg::*;

  cval_t  x    [CORDIC_STEPS];
  cval_t  y    [CORDIC_STEPS];
  cang_t  ang  [CORDIC_STEPS];
  cside_t side [CORDIC_STEPS];
  logic   vld  [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cval_t  xi, yi, dx, dy;
    cang_t  ai, at;
    cside_t si;
    logic   vi;

    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign ai = signed'({2'b00, in_r});
      assign si = in_side;
      assign vi = in_valid;
    end else begin : g_next
      assign xi = x[i-1];
      assign yi = y[i-1];
      assign ai = ang[i-1];
      assign si = side[i-1];
      assign vi = vld[i-1];
    end

    assign dx = yi >>> i;
    assign dy = xi >>> i;
    assign at = signed'({3'b000, atan_val(i)});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= vi;
      end
      if (!ai[34]) begin
        x[i]   <= xi - dx;
        y[i]   <= yi + dy;
        ang[i] <= ai - at;
      end else begin
        x[i]   <= xi + dx;
        y[i]   <= yi - dy;
        ang[i] <= ai + at;
      end
      side[i] <= si;
    end
  end

  assign out_valid = vld[CORDIC_STEPS-1];
  assign out_x     = x[CORDIC_STEPS-1];
  assign out_side  = side[CORDIC_STEPS-1];

endmodule

FILE: rtl/core/hpr_sqrt.sv
module hpr_sqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [63:0]     in_v,
  input  hpr_pkg::sside_t in_side,
  output logic            out_valid,
  output logic [31:0]     out_root,
  output hpr_pkg::sside_t out_side
);
  import hpr_pkg::*;

  logic [63:0] rem  [SQRT_STEPS];
  logic [63:0] res  [SQRT_STEPS];
  sside_t      side [SQRT_STEPS];
  logic        vld  [SQRT_STEPS];

  // restoring floor square root, one result bit per stage
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [63:0] BITV = 64'(1) << (62 - 2 * i);
    logic [63:0] ri, qi, trial;
    sside_t      si;
    logic        vi;

    if (i == 0) begin : g_first
      assign ri = in_v;
      assign qi = '0;
      assign si = in_side;
      assign vi = in_valid;
    end else begin : g_next
      assign ri = rem[i-1];
      assign qi = res[i-1];
      assign si = side[i-1];
      assign vi = vld[i-1];
    end

    assign trial = qi + BITV;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= vi;
      end
      if (ri >= trial) begin
        rem[i] <= ri - trial;
        res[i] <= (qi >> 1) + BITV;
      end else begin
        rem[i] <= ri;
        res[i] <= qi >> 1;
      end
      side[i] <= si;
    end
  end

  assign out_valid = vld[SQRT_STEPS-1];
  assign out_root  = res[SQRT_STEPS-1][31:0];
  assign out_side  = side[SQRT_STEPS-1];

endmodule

FILE: rtl/core/hpr_pix.sv
module hpr_pix (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [hpr_pkg::NSIDE_W-1:0]  n,
  input  logic                         in_valid,
  input  logic [31:0]                  in_root,
  input  hpr_pkg::sside_t              in_side,
  output logic                         out_valid,
  output logic [hpr_pkg::PIX_W-1:0]    out_pix
);
  import hpr_pkg::*;

  // ---- stage A: edge-line numerators (belt), n*root (cap)
  logic        a_vld;
  sside_t      a_side;
  logic [35:0] a_num_p, a_num_m;
  logic [45:0] a_p;

  logic [35:0] base;
  logic [32:0] z3;

  assign base = 36'h080000000 + {2'b00, in_side.t, 2'b00};
  assign z3   = 33'(in_side.za) * 33'd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= in_valid;
    end
    a_side <= in_side;
    if (in_side.neg) begin
      a_num_p <= base + 36'(z3);
      a_num_m <= base - 36'(z3);
    end else begin
      a_num_p <= base - 36'(z3);
      a_num_m <= base + 36'(z3);
    end
    a_p <= 46'(n) * 46'(in_root);
  end

  // ---- stage B: products
  logic        b_vld;
  sside_t      b_side;
  logic [49:0] b_pr_p, b_pr_m;
  logic [61:0] b_a1, b_b1, b_a2, b_b2;

  logic [29:0] tf;
  logic [30:0] u2;

  assign tf = a_side.t[29:0];
  assign u2 = 31'h40000000 - {1'b0, tf};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_side <= a_side;
    b_pr_p <= 50'(n) * 50'(a_num_p);
    b_pr_m <= 50'(n) * 50'(a_num_m);
    b_a1   <= 62'(tf[29:15]) * 62'(a_p);
    b_b1   <= 62'(tf[14:0]) * 62'(a_p);
    b_a2   <= 62'(u2[30:15]) * 62'(a_p);
    b_b2   <= 62'(u2[14:0]) * 62'(a_p);
  end

  // ---- stage C: ring indices
  logic               c_vld;
  sside_t             c_side;
  logic signed [19:0] c_irb, c_s;
  logic [17:0]        c_irc;
  logic [29:0]        c_nn;

  logic signed [19:0] jpb, jmb, nsg, irb;
  logic [62:0]        sum1, sum2;

  assign jpb  = signed'({2'b00, b_pr_p[49:32]});
  assign jmb  = signed'({2'b00, b_pr_m[49:32]});
  assign nsg  = signed'({6'b000000, n});
  assign irb  = nsg + 20'sd1 + jpb - jmb;
  assign sum1 = 63'(b_a1) + 63'(b_b1 >> 15);
  assign sum2 = 63'(b_a2) + 63'(b_b2 >> 15);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
    c_side <= b_side;
    c_irb  <= irb;
    c_s    <= jpb + jmb - nsg + signed'({19'd0, ~irb[0]}) + 20'sd1;
    c_irc  <= sum1[62:45] + sum2[62:45] + 18'd1;
    c_nn   <= 30'(n) * 30'(n);
  end

  // ---- stage D: belt ip with wrap, ring offsets
  logic        d_vld;
  sside_t      d_side;
  logic [19:0] d_ipb;
  logic [29:0] d_off, d_ncap, d_npix, d_q1, d_q2;
  logic [49:0] d_prod;
  logic [17:0] d_irc;

  logic [19:0] ipb_raw, n4;
  logic [29:0] irm1;

  assign ipb_raw = {1'b0, c_s[19:1]} + 20'd1;
  assign n4      = {4'b0000, n, 2'b00};
  assign irm1    = 30'(c_irb - 20'sd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= c_vld;
    end
    d_side <= c_side;
    d_ipb  <= (ipb_raw > n4) ? ipb_raw - n4 : ipb_raw;
    d_off  <= 30'(n4) * irm1;
    d_ncap <= (c_nn - 30'(n)) << 1;
    d_npix <= c_nn * 30'd12;
    d_q1   <= (30'(c_irc) * 30'(c_irc - 18'd1)) << 1;
    d_q2   <= (30'(c_irc) * 30'(c_irc + 18'd1)) << 1;
    d_prod <= 50'(c_side.t) * 50'(c_irc);
    d_irc  <= c_irc;
  end

  // ---- stage E: cap ip with wrap, belt pixel
  logic        e_vld;
  sside_t      e_side;
  logic [20:0] e_ipc;
  logic [29:0] e_pixb, e_npix, e_q1, e_q2;

  logic [20:0] ipc_raw, ir4;

  assign ipc_raw = {1'b0, d_prod[49:30]} + 21'd1;
  assign ir4     = {1'b0, d_irc, 2'b00};

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= d_vld;
    end
    e_side <= d_side;
    e_ipc  <= (ipc_raw > ir4) ? ipc_raw - ir4 : ipc_raw;
    e_pixb <= d_ncap + d_off + 30'(d_ipb);
    e_npix <= d_npix;
    e_q1   <= d_q1;
    e_q2   <= d_q2;
  end

  // ---- stage F: pick cap or belt
  logic [29:0] pixc;

  assign pixc = e_side.neg ? e_npix - e_q2 + 30'(e_ipc) : e_q1 + 30'(e_ipc);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= e_vld;
    end
    out_pix <= (e_side.belt ? e_pixb : pixc) - 30'd1;
  end

endmodule

FILE: rtl/core/sphere_angle_to_healpix_ring_top.sv
// HEALPix ring-order pixel lookup.
// Input word: theta_code (colatitude) and phi_code (longitude), taken at a
// rising edge with start high and busy low. busy never rises, so a new word
// may be issued on every cycle.
// Result: pixel_index, shown for one cycle with done high, once the word has
// passed 1 input stage, 32 CORDIC stages for cos(theta), 1 clamp stage,
// 32 square-root stages for the polar caps and 6 index stages.
// Throughput is one word per cycle.
// nside is written through cfg_valid/cfg_ready (ready is always high) and
// must only change while no word is in flight. Zero acts as 1; values above
// 2^NSIDE_MAX_LOG2 act as that limit.
// Reset (rst, synchronous) empties the pipeline and sets nside to 1.
// The receiver cannot stall: each done pulse must be taken when it shows.
module sphere_angle_to_healpix_ring_top #(
  parameter int ANGLE_BITS     = hpr_pkg::ANGLE_BITS_DEF,
  parameter int NSIDE_MAX_LOG2 = hpr_pkg::NSIDE_MAX_LOG2_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [ANGLE_BITS-1:0]       theta_code,
  input  logic [ANGLE_BITS-1:0]       phi_code,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hpr_pkg::NSIDE_W-1:0] nside,
  output logic                        done,
  output logic [hpr_pkg::PIX_W-1:0]   pixel_index
);
  import hpr_pkg::*;

  localparam logic [NSIDE_W-1:0] NMAX = NSIDE_W'(1) << NSIDE_MAX_LOG2;

  logic [NSIDE_W-1:0] n_cfg;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_cfg <= NSIDE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (nside == '0) begin
        n_cfg <= NSIDE_W'(1);
      end else if (nside > NMAX) begin
        n_cfg <= NMAX;
      end else begin
        n_cfg <= nside;
      end
    end
  end

  // align both codes to 32-bit binary angles
  logic [31:0] a32, t32;

  if (ANGLE_BITS >= 32) begin : g_down
    assign a32 = theta_code[ANGLE_BITS-1 -: 32];
    assign t32 = phi_code[ANGLE_BITS-1 -: 32];
  end else begin : g_up
    assign a32 = {theta_code, {(32 - ANGLE_BITS){1'b0}}};
    assign t32 = {phi_code, {(32 - ANGLE_BITS){1'b0}}};
  end

  // input stage: fold theta into [0, pi/2]
  logic        in_vld;
  logic [32:0] in_r;
  cside_t      in_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
    in_r        <= a32[31] ? 33'h100000000 - {1'b0, a32} : {1'b0, a32};
    in_side.neg <= a32[31];
    in_side.t   <= t32;
  end

  logic   co_vld;
  cval_t  co_x;
  cside_t co_side;

  hpr_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_vld),
    .in_r      (in_r),
    .in_side   (in_side),
    .out_valid (co_vld),
    .out_x     (co_x),
    .out_side  (co_side)
  );

  // clamp stage: |z| in Q1.30, belt decision, radicand
  logic [32:0] cclamp;
  logic [30:0] za;

  always_comb begin
    if (co_x[35]) begin
      cclamp = '0;
    end else if (co_x > 36'sh100000000) begin
      cclamp = 33'h100000000;
    end else begin
      cclamp = co_x[32:0];
    end
  end

  assign za = cclamp[32:2];

  logic        q_vld;
  sside_t      q_side;
  logic [31:0] q_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else begin
      q_vld <= co_vld;
    end
    q_side.neg  <= co_side.neg;
    q_side.t    <= co_side.t;
    q_side.za   <= za;
    q_side.belt <= (33'(za) * 33'd3) <= 33'h080000000;
    q_w         <= 32'(32'h40000000 - 32'(za)) * 32'd3;
  end

  logic        sq_vld;
  logic [31:0] sq_root;
  sside_t      sq_side;

  hpr_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_vld),
    .in_v      ({2'b00, q_w, 30'd0}),
    .in_side   (q_side),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  hpr_pix u_pix (
    .clk       (clk),
    .rst       (rst),
    .n         (n_cfg),
    .in_valid  (sq_vld),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (done),
    .out_pix   (pixel_index)
  );

endmodule
